/* src/stt_pkg.sv */
// Shared types, constants and byte classification helpers for the source text tokenizer.
// No dependencies.
package stt_pkg;

  localparam int POS_BITS = 16;
  localparam int OUT_POS_W = 16;
  localparam int VALUE_W = 31;
  localparam int KIND_W = 3;
  localparam int SUM_W = VALUE_W + 4;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [VALUE_W-1:0] NUM_LIMIT = '1;

  localparam logic [KIND_W-1:0] KIND_KW_RETURN = 3'd0;
  localparam logic [KIND_W-1:0] KIND_KW_INT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUNCT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IDENT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd4;
  localparam logic [KIND_W-1:0] KIND_END = 3'd5;
  localparam logic [KIND_W-1:0] KIND_INVALID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_TOO_LARGE = 3'd7;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_IDENT  = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_HALT   = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [OUT_POS_W-1:0] start_pos;
    logic [OUT_POS_W-1:0] length;
    logic [VALUE_W-1:0]   value;
    logic                 last;
  } token_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic logic [7:0] return_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = 8'h72;
      3'd1: r = 8'h65;
      3'd2: r = 8'h74;
      3'd3: r = 8'h75;
      3'd4: r = 8'h72;
      3'd5: r = 8'h6e;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] int_char(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0: r = 8'h69;
      2'd1: r = 8'h6e;
      2'd2: r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] p);
    return (p == POS_MAX) ? p : p + POS_BITS'(1);
  endfunction

endpackage

/* src/source_text_tokenizer.sv */
// Source text tokenizer top level: scanner state, token formation and a result queue.
// Depends on stt_pkg.
//
// Usage: text bytes enter on the input channel (in_valid, in_ready, ch, end_of_text),
// one item per byte, and a final item with end_of_text high closes the text.
// Tokens leave on the output channel (out_valid, out_ready, kind, start_pos, length,
// value, last); last marks the final token caused by one input item.
// An accepted item is classified and the scanner state is updated in the same cycle,
// so one item can be taken every cycle while in_ready is high. Each item causes zero,
// one or two tokens, which are written into a four-entry result queue; a token is
// registered there and offered on the outputs once the tokens ahead of it have left.
// in_ready is high while the queue has room for two tokens, so the queue depth sets
// the figure: with out_ready held high the block sustains one item per cycle, and
// only an item that causes two tokens in a row of such items can add a bubble.
// When the receiver stalls the queue fills and in_ready drops; no token is lost.
// Reset empties the queue and returns the scanner to idle at text position zero;
// an end marker does the same to the scanner as its tokens are queued.
module source_text_tokenizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    ch,
  input  logic                          end_of_text,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stt_pkg::KIND_W-1:0]    kind,
  output logic [stt_pkg::OUT_POS_W-1:0] start_pos,
  output logic [stt_pkg::OUT_POS_W-1:0] length,
  output logic [stt_pkg::VALUE_W-1:0]   value,
  output logic                          last
);
  import stt_pkg::*;

  scan_mode_t           scan_mode, scan_mode_next;
  logic [POS_BITS-1:0]  token_start, token_start_next;
  logic [POS_BITS-1:0]  token_length, token_length_next;
  logic [VALUE_W-1:0]   number_accum, number_accum_next;
  logic [1:0]           keyword_match, keyword_match_next;
  logic [POS_BITS-1:0]  text_position, text_position_next;

  token_t               queue [4];
  logic [1:0]           head;
  logic [1:0]           tail;
  logic [2:0]           count;

  logic                 accept;
  logic                 pop;
  token_t               res [2];
  logic [1:0]           n_res;
  logic                 fresh;
  token_t               ident_tok;
  token_t               number_tok;
  token_t               end_tok;
  token_t               byte_tok;
  logic [SUM_W-1:0]     sum;
  logic                 ret_hit;
  logic                 int_hit;

  assign accept = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign in_ready = (count <= 3'd2);
  assign out_valid = (count != 3'd0);

  assign kind = queue[head].kind;
  assign start_pos = queue[head].start_pos;
  assign length = queue[head].length;
  assign value = queue[head].value;
  assign last = queue[head].last;

  always_comb begin
    ident_tok.kind = KIND_IDENT;
    if (keyword_match[0] && token_length == POS_BITS'(6)) begin
      ident_tok.kind = KIND_KW_RETURN;
    end else if (keyword_match[1] && token_length == POS_BITS'(3)) begin
      ident_tok.kind = KIND_KW_INT;
    end
    ident_tok.start_pos = OUT_POS_W'(token_start);
    ident_tok.length = OUT_POS_W'(token_length);
    ident_tok.value = '0;
    ident_tok.last = 1'b0;

    number_tok.kind = (number_accum == NUM_LIMIT) ? KIND_TOO_LARGE : KIND_NUMBER;
    number_tok.start_pos = OUT_POS_W'(token_start);
    number_tok.length = OUT_POS_W'(token_length);
    number_tok.value = number_accum;
    number_tok.last = 1'b0;

    end_tok.kind = KIND_END;
    end_tok.start_pos = OUT_POS_W'(text_position);
    end_tok.length = '0;
    end_tok.value = '0;
    end_tok.last = 1'b1;

    byte_tok.kind = is_punct(ch) ? KIND_PUNCT : KIND_INVALID;
    byte_tok.start_pos = OUT_POS_W'(text_position);
    byte_tok.length = OUT_POS_W'(1);
    byte_tok.value = VALUE_W'(ch);
    byte_tok.last = 1'b0;

    sum = (SUM_W'(number_accum) << 3) + (SUM_W'(number_accum) << 1) + SUM_W'(ch[3:0]);
    ret_hit = (token_length < POS_BITS'(6)) && (ch == return_char(token_length[2:0]));
    int_hit = (token_length < POS_BITS'(3)) && (ch == int_char(token_length[1:0]));
  end

  always_comb begin
    scan_mode_next = scan_mode;
    token_start_next = token_start;
    token_length_next = token_length;
    number_accum_next = number_accum;
    keyword_match_next = keyword_match;
    text_position_next = text_position;
    res[0] = '0;
    res[1] = '0;
    n_res = 2'd0;
    fresh = 1'b0;
    if (accept) begin
      if (end_of_text) begin
        if (scan_mode == MODE_IDENT) begin
          res[0] = ident_tok;
          n_res = 2'd1;
        end else if (scan_mode == MODE_NUMBER) begin
          res[0] = number_tok;
          n_res = 2'd1;
        end
        res[n_res[0]] = end_tok;
        n_res = n_res + 2'd1;
        scan_mode_next = MODE_IDLE;
        token_start_next = '0;
        token_length_next = '0;
        number_accum_next = '0;
        keyword_match_next = 2'b11;
        text_position_next = '0;
      end else begin
        case (scan_mode)
          MODE_IDENT: begin
            if (is_letter(ch) || is_digit(ch) || ch == 8'h5f) begin
              keyword_match_next = keyword_match & {int_hit, ret_hit};
              token_length_next = sat_inc(token_length);
            end else begin
              res[0] = ident_tok;
              n_res = 2'd1;
              fresh = 1'b1;
              scan_mode_next = MODE_IDLE;
            end
          end
          MODE_NUMBER: begin
            if (is_digit(ch)) begin
              number_accum_next = (sum >= SUM_W'(NUM_LIMIT)) ? NUM_LIMIT : VALUE_W'(sum);
              token_length_next = sat_inc(token_length);
            end else begin
              res[0] = number_tok;
              n_res = 2'd1;
              fresh = 1'b1;
              scan_mode_next = MODE_IDLE;
            end
          end
          MODE_IDLE: fresh = 1'b1;
          MODE_HALT: fresh = 1'b0;
          default: fresh = 1'b0;
        endcase
        if (fresh && !is_space(ch)) begin
          if (is_letter(ch)) begin
            scan_mode_next = MODE_IDENT;
            token_start_next = text_position;
            token_length_next = POS_BITS'(1);
            keyword_match_next = {ch == 8'h69, ch == 8'h72};
          end else if (is_digit(ch)) begin
            scan_mode_next = MODE_NUMBER;
            token_start_next = text_position;
            token_length_next = POS_BITS'(1);
            number_accum_next = VALUE_W'(ch[3:0]);
          end else begin
            res[n_res[0]] = byte_tok;
            n_res = n_res + 2'd1;
            if (!is_punct(ch)) begin
              scan_mode_next = MODE_HALT;
            end
          end
        end
        text_position_next = sat_inc(text_position);
        if (n_res == 2'd1) begin
          res[0].last = 1'b1;
        end else if (n_res == 2'd2) begin
          res[1].last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_IDLE;
      token_start <= '0;
      token_length <= '0;
      number_accum <= '0;
      keyword_match <= 2'b11;
      text_position <= '0;
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      scan_mode <= scan_mode_next;
      token_start <= token_start_next;
      token_length <= token_length_next;
      number_accum <= number_accum_next;
      keyword_match <= keyword_match_next;
      text_position <= text_position_next;
      tail <= tail + n_res;
      if (pop) begin
        head <= head + 2'd1;
      end
      count <= count + 3'(n_res) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      queue[tail] <= res[0];
    end
    if (n_res == 2'd2) begin
      queue[tail + 2'd1] <= res[1];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue count out of range");

  a_accum_bound: assert property (@(posedge clk) disable iff (rst)
    number_accum <= NUM_LIMIT)
    else $error("number accumulator above limit");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |=> (scan_mode == MODE_IDLE && text_position == '0))
    else $error("end marker did not clear the scanner");

  a_end_queues: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text && !pop) |=> (count > $past(count)))
    else $error("end marker queued no token");

endmodule
